/* rtl/dht_pkg.sv */
`default_nettype none
package dht_pkg;

	// table geometry
	localparam int MAX_SLOTS = 1024;
	localparam int SLOT_AW   = 10;
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = 11;
	localparam int LG_W      = 4;
	localparam int ST_W      = 2;
	localparam int RES_W     = 3;
	localparam int ENTRY_W   = ST_W + VAL_W + KEY_W;

	localparam logic [LG_W-1:0] LG_MIN   = 4'd5;
	localparam logic [LG_W-1:0] LG_MAX   = 4'd10;
	localparam logic [LG_W-1:0] LG_RESET = 4'd5;

	// operation codes
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;

	// slot states
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd0;
	localparam logic [ST_W-1:0] ST_LIVE  = 2'd1;
	localparam logic [ST_W-1:0] ST_TOMB  = 2'd2;

	// result codes
	localparam logic [RES_W-1:0] RES_NEW       = 3'd0;
	localparam logic [RES_W-1:0] RES_REUSED    = 3'd1;
	localparam logic [RES_W-1:0] RES_REPLACED  = 3'd2;
	localparam logic [RES_W-1:0] RES_FOUND     = 3'd3;
	localparam logic [RES_W-1:0] RES_NOT_FOUND = 3'd4;
	localparam logic [RES_W-1:0] RES_DELETED   = 3'd5;
	localparam logic [RES_W-1:0] RES_FULL      = 3'd6;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic eval;
		logic out_load;
		logic clear_wr;
	} dht_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic finish;
		logic out_free;
		logic clear_last;
	} dht_sts_t;

	// probe step primes
	function automatic logic [13:0] step_prime(input logic [2:0] idx);
		logic [13:0] p;
		unique case (idx)
			3'd0: p = 14'd9923;
			3'd1: p = 14'd9929;
			3'd2: p = 14'd9931;
			3'd3: p = 14'd9941;
			3'd4: p = 14'd9949;
			3'd5: p = 14'd9967;
			3'd6: p = 14'd9973;
			3'd7: p = 14'd10007;
		endcase
		return p;
	endfunction

	// clamp the size register to the supported range
	function automatic logic [LG_W-1:0] lg_in_use(input logic [LG_W-1:0] lg);
		logic [LG_W-1:0] r;
		r = lg;
		if (lg < LG_MIN) begin
			r = LG_MIN;
		end else if (lg > LG_MAX) begin
			r = LG_MAX;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/double_hash_table_engine_core.sv */
// after reset all 1024 slots of the slot memory are swept clear in turn; no request is taken meanwhile
// a request probing p slots does one memory read per probe, each read followed by its evaluation
// the result shows on m_axis_tvalid after the last probe is evaluated, once the output register is free
// one request at a time; the next is taken while a result still waits at the output
// reset: asynchronous, active low; size register returns to 5, table empty, count zero
`default_nettype none
module double_hash_table_engine_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [dht_pkg::LG_W-1:0] cfg_wr_data,   // table_size_log2
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire logic [63:0]              s_axis_tdata,  // key[31:0], value_in[63:32]
	input  wire logic [1:0]               s_axis_tuser,  // kind[1:0]
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	output logic      [63:0]              m_axis_tdata   // status[2:0], value_out[34:3],
	                                                     // probe_count[45:35], entry_count[56:46]
);
	import dht_pkg::*;

	dht_cmd_t cmd;
	dht_sts_t sts;

	dht_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.cmd          (cmd),
		.sts          (sts)
	);

	dht_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
`default_nettype wire

/* rtl/dht_ram.sv */
`default_nettype none
module dht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AddrW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AddrW-1:0] wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AddrW-1:0] rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

/* rtl/dht_ctrl.sv */
`default_nettype none
module dht_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	output dht_pkg::dht_cmd_t      cmd,
	input  wire dht_pkg::dht_sts_t sts
);
	import dht_pkg::*;

	typedef enum logic [2:0] {
		CLEAR,
		IDLE,
		READ,
		EVAL,
		DONE
	} state_t;

	state_t state_q;

	assign s_axis_tready = (state_q == IDLE);

	// commands follow the state
	always_comb begin
		cmd = '0;
		cmd.clear_wr = (state_q == CLEAR);
		cmd.load     = (state_q == IDLE) && s_axis_tvalid;
		cmd.eval     = (state_q == EVAL);
		cmd.out_load = (state_q == DONE) && sts.out_free;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
		end else begin
			unique case (state_q)
				CLEAR: begin
					if (sts.clear_last) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= READ;
					end
				end
				READ: begin
					state_q <= EVAL;
				end
				EVAL: begin
					state_q <= sts.finish ? DONE : READ;
				end
				DONE: begin
					if (sts.out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= CLEAR;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/dht_datapath.sv */
`default_nettype none
module dht_datapath (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [dht_pkg::LG_W-1:0] cfg_wr_data,
	input  wire logic [63:0]              s_axis_tdata,  // key, value_in
	input  wire logic [1:0]               s_axis_tuser,  // kind
	output logic                          m_axis_tvalid,
	input  wire logic                     m_axis_tready,
	output logic      [63:0]              m_axis_tdata,  // status, value_out, probe_count, entry_count
	input  wire dht_pkg::dht_cmd_t        cmd,
	output dht_pkg::dht_sts_t             sts
);
	import dht_pkg::*;

	// size register
	logic [LG_W-1:0] cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= LG_RESET;
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	// hash of the incoming request
	logic [LG_W-1:0]    lg_use;
	logic [SLOT_AW:0]   mask_full;
	logic [SLOT_AW-1:0] mask_in;
	logic [KEY_W-1:0]   in_key;
	logic [KEY_W-1:0]   key_sh;
	logic [SLOT_AW-1:0] home_in;
	logic [2:0]         step_idx;
	logic [13:0]        prime;

	always_comb begin
		lg_use    = lg_in_use(cfg_q);
		mask_full = ((SLOT_AW+1)'(1) << lg_use) - (SLOT_AW+1)'(1);
		mask_in   = mask_full[SLOT_AW-1:0];
		in_key    = s_axis_tdata[KEY_W-1:0];
		key_sh    = in_key >> lg_use;
		home_in   = in_key[SLOT_AW-1:0] & mask_in;
		step_idx  = home_in[2:0] + key_sh[2:0];
		prime     = step_prime(step_idx);
	end

	// request registers and probe position
	logic [1:0]         kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;
	logic [SLOT_AW-1:0] mask_q;
	logic [SLOT_AW-1:0] home_q;
	logic [SLOT_AW-1:0] step_q;
	logic [SLOT_AW-1:0] look_q;
	logic [CNT_W-1:0]   probes_q;

	// slot read data
	logic [ENTRY_W-1:0] rd_data;
	logic [ST_W-1:0]    rd_st;
	logic [VAL_W-1:0]   rd_val;
	logic [KEY_W-1:0]   rd_key;
	logic               key_eq;
	logic [SLOT_AW-1:0] next_look;
	logic               wrap;

	assign rd_st     = rd_data[ENTRY_W-1 -: ST_W];
	assign rd_val    = rd_data[KEY_W +: VAL_W];
	assign rd_key    = rd_data[KEY_W-1:0];
	assign key_eq    = (rd_key == key_q);
	assign next_look = (look_q + step_q) & mask_q;
	assign wrap      = (next_look == home_q);

	// decision on the slot just read
	logic             finish;
	logic             slot_wr;
	logic [ST_W-1:0]  wr_st;
	logic [VAL_W-1:0] wr_val;
	logic [RES_W-1:0] res;
	logic [VAL_W-1:0] vout;
	logic             live_inc;
	logic             live_dec;

	always_comb begin
		finish   = 1'b0;
		slot_wr  = 1'b0;
		wr_st    = ST_LIVE;
		wr_val   = val_q;
		res      = RES_NOT_FOUND;
		vout     = '0;
		live_inc = 1'b0;
		live_dec = 1'b0;
		unique case (kind_q)
			KIND_INSERT: begin
				res = RES_FULL;
				priority if (rd_st == ST_LIVE && key_eq) begin
					finish  = 1'b1;
					slot_wr = 1'b1;
					res     = RES_REPLACED;
				end else if (rd_st == ST_EMPTY) begin
					finish   = 1'b1;
					slot_wr  = 1'b1;
					res      = RES_NEW;
					live_inc = 1'b1;
				end else if (rd_st == ST_TOMB && key_eq) begin
					finish   = 1'b1;
					slot_wr  = 1'b1;
					res      = RES_REUSED;
					live_inc = 1'b1;
				end else begin
					finish = wrap;
				end
			end
			KIND_LOOKUP, KIND_DELETE: begin
				priority if (rd_st == ST_LIVE && key_eq) begin
					finish = 1'b1;
					if (kind_q == KIND_LOOKUP) begin
						res  = RES_FOUND;
						vout = rd_val;
					end else begin
						slot_wr  = 1'b1;
						wr_st    = ST_TOMB;
						wr_val   = rd_val;
						res      = RES_DELETED;
						live_dec = 1'b1;
					end
				end else begin
					finish = (rd_st == ST_EMPTY) || wrap;
				end
			end
			default: begin
				finish = 1'b1;
			end
		endcase
	end

	// probe control
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= s_axis_tuser;
			key_q    <= in_key;
			val_q    <= s_axis_tdata[KEY_W +: VAL_W];
			mask_q   <= mask_in;
			home_q   <= home_in;
			step_q   <= prime[SLOT_AW-1:0];
			look_q   <= home_in;
			probes_q <= '0;
		end else if (cmd.eval && !finish) begin
			look_q   <= next_look;
			probes_q <= probes_q + 1'b1;
		end
	end

	// clearing sweep after reset
	logic [SLOT_AW-1:0] clear_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_idx_q <= '0;
		end else if (cmd.clear_wr) begin
			clear_idx_q <= clear_idx_q + 1'b1;
		end
	end

	// slot memory: state, value, key
	logic               ram_we;
	logic [SLOT_AW-1:0] ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;

	always_comb begin
		ram_we    = cmd.clear_wr || (cmd.eval && slot_wr);
		ram_waddr = cmd.clear_wr ? clear_idx_q : look_q;
		ram_wdata = cmd.clear_wr ? '0 : {wr_st, wr_val, key_q};
	end

	dht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_SLOTS)
	) u_slots (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_addr(look_q),
		.rd_data(rd_data)
	);

	// live entry count
	logic [CNT_W-1:0] live_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (cmd.eval) begin
			if (live_inc) begin
				live_q <= live_q + 1'b1;
			end else if (live_dec && live_q != '0) begin
				live_q <= live_q - 1'b1;
			end
		end
	end

	// result held until the output register is free
	logic [RES_W-1:0] res_status_q;
	logic [VAL_W-1:0] res_vout_q;
	logic [CNT_W-1:0] res_probe_q;

	always_ff @(posedge clk) begin
		if (cmd.eval && finish) begin
			res_status_q <= res;
			res_vout_q   <= vout;
			res_probe_q  <= (kind_q == KIND_INSERT) ? probes_q + 1'b1 : '0;
		end
	end

	// output register
	logic        m_valid_q;
	logic [63:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_data_q <= {7'd0, live_q, res_probe_q, res_vout_q, res_status_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_comb begin
		sts            = '0;
		sts.finish     = finish;
		sts.out_free   = !m_valid_q || m_axis_tready;
		sts.clear_last = (clear_idx_q == '1);
	end

endmodule
`default_nettype wire

/* rtl/dht_checker.sv */
`default_nettype none
module dht_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [63:0] m_axis_tdata
);
	import dht_pkg::*;

	logic [RES_W-1:0] st;
	assign st = m_axis_tdata[RES_W-1:0];

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one request in flight: no request taken right after another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while busy");

	// only defined result codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> st != 3'd7)
		else $error("undefined result code");

	// non-insert results report no probes
	a_probe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (st == RES_FOUND || st == RES_NOT_FOUND || st == RES_DELETED)
		|-> m_axis_tdata[45:35] == '0)
		else $error("probe count on a non-insert result");

endmodule

bind double_hash_table_engine_core dht_checker u_dht_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

/* verif/double_hash_table_engine_core_tb.sv */
`timescale 1ns / 1ps
module double_hash_table_engine_core_tb;
	import dht_pkg::*;

	// kind code the block does not define
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] key;
		logic [31:0] value;
	} table_op_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] value;
		logic [10:0] probes;
		logic [10:0] entries;
	} table_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [3:0]  cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;

	double_hash_table_engine_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// shadow copy of the table
	logic [31:0]     shadow_key   [1024];
	logic [31:0]     shadow_value [1024];
	logic [ST_W-1:0] shadow_state [1024] = '{default: ST_EMPTY};
	int unsigned     shadow_live = 0;
	logic [3:0]      shadow_size_lg = 4'd5;

	table_op_t  pending_ops[$];
	table_res_t expected_results[$];
	int         mismatch_count = 0;
	int         result_index = 0;
	bit         idling_on = 1'b1;
	int         send_gap = 0;
	int         recv_stall = 0;

	const int unsigned step_primes [8] = '{9923, 9929, 9931, 9941, 9949, 9967, 9973, 10007};

	// apply one operation to the shadow table and return its result
	function automatic table_res_t apply_table_op(input table_op_t op);
		table_res_t  r;
		int unsigned lg;
		int unsigned mask_v;
		int unsigned home;
		int unsigned step;
		int unsigned slot;
		bit          done;
		lg = shadow_size_lg;
		if (lg < 5) begin
			lg = 5;
		end else if (lg > 10) begin
			lg = 10;
		end
		mask_v = (1 << lg) - 1;
		home = op.key & mask_v;
		step = step_primes[(home + (op.key >> lg)) & 7];
		slot = home;
		done = 1'b0;
		r = '0;
		r.status = RES_NOT_FOUND;
		if (op.kind == KIND_INSERT) begin
			r.status = RES_FULL;
			while (!done) begin
				r.probes = r.probes + 11'd1;
				if (shadow_state[slot] == ST_LIVE && shadow_key[slot] == op.key) begin
					shadow_value[slot] = op.value;
					r.status = RES_REPLACED;
					done = 1'b1;
				end else if (shadow_state[slot] == ST_EMPTY) begin
					shadow_key[slot] = op.key;
					shadow_value[slot] = op.value;
					shadow_state[slot] = ST_LIVE;
					shadow_live++;
					r.status = RES_NEW;
					done = 1'b1;
				end else if (shadow_state[slot] == ST_TOMB && shadow_key[slot] == op.key) begin
					shadow_value[slot] = op.value;
					shadow_state[slot] = ST_LIVE;
					shadow_live++;
					r.status = RES_REUSED;
					done = 1'b1;
				end else begin
					slot = (slot + step) & mask_v;
					done = (slot == home);
				end
			end
		end else if (op.kind == KIND_LOOKUP || op.kind == KIND_DELETE) begin
			while (!done) begin
				if (shadow_state[slot] == ST_LIVE && shadow_key[slot] == op.key) begin
					if (op.kind == KIND_LOOKUP) begin
						r.value = shadow_value[slot];
						r.status = RES_FOUND;
					end else begin
						shadow_state[slot] = ST_TOMB;
						if (shadow_live > 0) begin
							shadow_live--;
						end
						r.status = RES_DELETED;
					end
					done = 1'b1;
				end else if (shadow_state[slot] == ST_EMPTY) begin
					done = 1'b1;
				end else begin
					slot = (slot + step) & mask_v;
					done = (slot == home);
				end
			end
		end
		r.entries = 11'(shadow_live);
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_requests
		table_op_t next_op;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			send_gap <= 0;
		end else begin
			// request taken: predict its result
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(apply_table_op(
					{s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]}));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (idling_on && pending_ops.size() != 0
				             && $urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(0, 2);
					s_axis_tvalid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					next_op = pending_ops.pop_front();
					s_axis_tdata <= {next_op.value, next_op.key};
					s_axis_tuser <= next_op.kind;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : watch_results
		table_res_t want;
		table_res_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[45:35],
				       m_axis_tdata[56:46]};
				if (expected_results.size() == 0) begin
					flag_mismatch($sformatf("result %0d arrived with none pending: %h",
					                        result_index, m_axis_tdata));
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						flag_mismatch($sformatf(
							"result %0d status %0d/%0d value %h/%h probes %0d/%0d entries %0d/%0d",
							result_index, got.status, want.status, got.value, want.value,
							got.probes, want.probes, got.entries, want.entries));
					end
				end
				result_index++;
			end
			if (recv_stall != 0) begin
				recv_stall <= recv_stall - 1;
				m_axis_tready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 4) == 0) begin
				recv_stall <= $urandom_range(0, 2);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic push_op(input logic [1:0] kind, input logic [31:0] key,
	                       input logic [31:0] value);
		pending_ops.push_back({kind, key, value});
	endtask

	// wait until every request went out and every result came back
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
	endtask

	task automatic write_table_size(input logic [3:0] lg);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lg;
		shadow_size_lg = lg;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// random operations over a pool of keys, part of them sharing a home slot
	task automatic queue_random_ops(input int count, input int pool_n, input int insert_pct);
		logic [31:0] pool [$];
		logic [31:0] k;
		logic [1:0]  kind;
		int          pick;
		for (int i = 0; i < pool_n; i++) begin
			k = $urandom;
			if (i > 0 && $urandom_range(0, 2) == 0) begin
				k[9:0] = pool[i - 1][9:0];
			end
			pool.push_back(k);
		end
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < insert_pct) begin
				kind = KIND_INSERT;
			end else if (pick < insert_pct + 25) begin
				kind = KIND_LOOKUP;
			end else if (pick < 95) begin
				kind = KIND_DELETE;
			end else begin
				kind = KIND_UNUSED;
			end
			if ($urandom_range(0, 99) < 85) begin
				k = pool[$urandom_range(0, pool_n - 1)];
			end else begin
				k = $urandom;
			end
			push_op(kind, k, $urandom);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, replace, collisions on slot 0, tombstones, unused kind
		push_op(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		push_op(KIND_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
		push_op(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
		push_op(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		push_op(KIND_INSERT, 32'h0000_0020, 32'h1234_5678);
		push_op(KIND_INSERT, 32'hFFFF_FFFF, 32'h5555_5555);
		push_op(KIND_INSERT, 32'hFFFF_FFE0, 32'hAAAA_AAAA);
		push_op(KIND_DELETE, 32'h0000_0000, 32'h0000_0000);
		push_op(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		push_op(KIND_LOOKUP, 32'h0000_0020, 32'h0000_0000);
		push_op(KIND_LOOKUP, 32'hFFFF_FFE0, 32'h0000_0000);
		push_op(KIND_INSERT, 32'h0000_0040, 32'h0F0F_0F0F);
		push_op(KIND_INSERT, 32'h0000_0000, 32'h8000_0001);
		push_op(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000);
		push_op(KIND_UNUSED, 32'h0000_0000, 32'h0000_0000);
		push_op(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(KIND_DELETE, 32'h0000_0020, 32'h0000_0000);
		push_op(KIND_DELETE, 32'h0000_0020, 32'h0000_0000);
		push_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
		push_op(KIND_INSERT, 32'h0000_0020, 32'hFFFF_FFFF);
		wait_idle();

		// below range, clamps to 32 slots: insert heavy so the table fills up
		write_table_size(4'd0);
		queue_random_ops(250, 44, 65);
		wait_idle();

		// above range, clamps to 1024 slots with old entries left in place
		write_table_size(4'd15);
		queue_random_ops(150, 300, 55);
		wait_idle();

		write_table_size(4'd6);
		queue_random_ops(200, 90, 55);
		wait_idle();

		write_table_size(4'd8);
		queue_random_ops(150, 250, 50);
		wait_idle();

		write_table_size(4'd7);
		queue_random_ops(150, 100, 50);
		wait_idle();

		// last stretch runs without idling
		idling_on = 1'b0;
		write_table_size(4'd10);
		queue_random_ops(100, 120, 50);
		wait_idle();

		repeat (64) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("double_hash_table_engine_core_tb passed");
		end else begin
			$display("double_hash_table_engine_core_tb failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#100_000_000;
		$display("double_hash_table_engine_core_tb failed");
		$finish;
	end

endmodule
